// File: src/background_range_pixel_update_defines.svh
// assertion helpers for the top-level rtl file
`ifndef BACKGROUND_RANGE_PIXEL_UPDATE_DEFINES_SVH
`define BACKGROUND_RANGE_PIXEL_UPDATE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BRPU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define BRPU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/brpu_pkg.sv
package brpu_pkg;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [PIX_W-1:0] K8_ONE     = 8'h01;
  localparam logic [PIX_W-1:0] K_ZERO     = 8'h00;
  localparam logic [PIX_W-1:0] K_ALL_ONES = 8'hFF;

  typedef enum logic [2:0] {
    MODE_GROW_SLOW    = 3'd0,
    MODE_GROW_FAST    = 3'd1,
    MODE_COUNT        = 3'd2,
    MODE_ADJUST       = 3'd3,
    MODE_ADJUST_GATED = 3'd4,
    MODE_SHIFT        = 3'd5,
    MODE_SHIFT_GATED  = 3'd6,
    MODE_LABEL        = 3'd7
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] REG_UPDATE_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LABEL_MATCH     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LABEL_FILL      = 2'd3;

  typedef struct packed {
    mode_t            update_mode;
    logic [PIX_W-1:0] count_threshold;
    logic [PIX_W-1:0] label_match;
    logic [PIX_W-1:0] label_fill;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [PIX_W-1:0] lo_in;
    logic [PIX_W-1:0] hi_in;
    logic [PIX_W-1:0] lo_count_in;
    logic [PIX_W-1:0] hi_count_in;
    logic [PIX_W-1:0] gate;
    logic [PIX_W-1:0] label_in;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] lo_out;
    logic [PIX_W-1:0] hi_out;
    logic [PIX_W-1:0] lo_count_out;
    logic [PIX_W-1:0] hi_count_out;
    logic [PIX_W-1:0] label_out;
  } out_t;

  function automatic logic [PIX_W-1:0] add_sat(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
    logic [PIX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[PIX_W] ? K_ALL_ONES : s[PIX_W-1:0];
  endfunction

  function automatic logic [PIX_W-1:0] sub_sat(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
    return (a > b) ? (a - b) : K_ZERO;
  endfunction

endpackage

// File: src/brpu_cfg.sv
module brpu_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [brpu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [brpu_pkg::CFG_W-1:0]     cfg_wdata,
  output brpu_pkg::cfg_t                cfg
);
  import brpu_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.update_mode     <= MODE_GROW_SLOW;
      cfg_r.count_threshold <= K_ZERO;
      cfg_r.label_match     <= K_ZERO;
      cfg_r.label_fill      <= K_ZERO;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_UPDATE_MODE:     cfg_r.update_mode     <= mode_t'(cfg_wdata[2:0]);
        REG_COUNT_THRESHOLD: cfg_r.count_threshold <= cfg_wdata;
        REG_LABEL_MATCH:     cfg_r.label_match     <= cfg_wdata;
        REG_LABEL_FILL:      cfg_r.label_fill      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: src/brpu_update.sv
module brpu_update (
  input  brpu_pkg::cfg_t cfg,
  input  brpu_pkg::in_t  din,
  output brpu_pkg::out_t dout
);
  import brpu_pkg::*;

  logic             g;
  logic [PIX_W-1:0] m;
  logic [PIX_W-1:0] add_v;
  logic [PIX_W-1:0] sub_v;
  logic [PIX_W-1:0] t;
  logic             below;
  logic             above;

  assign t     = cfg.count_threshold;
  assign below = din.pixel < din.lo_in;
  assign above = din.pixel > din.hi_in;
  assign g     = (cfg.update_mode == MODE_ADJUST) ? 1'b1 : din.gate[0];
  assign m     = (cfg.update_mode == MODE_SHIFT) ? K_ALL_ONES : din.gate;
  assign add_v = m & sub_sat(din.pixel, din.hi_in);
  assign sub_v = m & sub_sat(din.lo_in, din.pixel);

  always_comb begin
    dout.lo_out       = din.lo_in;
    dout.hi_out       = din.hi_in;
    dout.lo_count_out = din.lo_count_in;
    dout.hi_count_out = din.hi_count_in;
    dout.label_out    = din.label_in;
    unique case (cfg.update_mode)
      MODE_GROW_SLOW: begin
        dout.hi_out = add_sat(din.hi_in, above ? K8_ONE : K_ZERO);
        dout.lo_out = sub_sat(din.lo_in, below ? K8_ONE : K_ZERO);
      end
      MODE_GROW_FAST: begin
        if (below) dout.lo_out = din.pixel;
        if (above) dout.hi_out = din.pixel;
      end
      MODE_COUNT: begin
        dout.lo_count_out = add_sat(din.lo_count_in, below ? K8_ONE : K_ZERO);
        dout.hi_count_out = add_sat(din.hi_count_in, above ? K8_ONE : K_ZERO);
      end
      MODE_ADJUST, MODE_ADJUST_GATED: begin
        // add first, then subtract, both saturating
        dout.lo_out = sub_sat(
          add_sat(din.lo_in, (g && din.lo_count_in < t) ? K8_ONE : K_ZERO),
          (g && din.lo_count_in > t) ? K8_ONE : K_ZERO);
        dout.hi_out = sub_sat(
          add_sat(din.hi_in, (g && din.hi_count_in > t) ? K8_ONE : K_ZERO),
          (g && din.hi_count_in < t) ? K8_ONE : K_ZERO);
        dout.lo_count_out = K_ZERO;
        dout.hi_count_out = K_ZERO;
      end
      MODE_SHIFT, MODE_SHIFT_GATED: begin
        dout.lo_out = sub_sat(add_sat(din.lo_in, add_v), sub_v);
        dout.hi_out = sub_sat(add_sat(din.hi_in, add_v), sub_v);
      end
      MODE_LABEL: begin
        if (din.pixel == cfg.label_match) dout.label_out = cfg.label_fill;
      end
      default: ;
    endcase
  end

endmodule

// File: src/background_range_pixel_update.sv
// Min/max background model update, one pixel per clock. Each transfer on the
// input channel carries a pixel with its stored bounds, counters, gate and
// label; the mode register picks the update. A pixel is captured in an input
// register, updated by one pass of saturating 8-bit logic and held in the
// result register; the sustained rate is one pixel per cycle whenever the
// output is not stalled. Configuration registers must only be written while
// no pixel is in flight.
`include "background_range_pixel_update_defines.svh"

module background_range_pixel_update (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [brpu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [brpu_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  brpu_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output brpu_pkg::out_t                 out_data
);
  import brpu_pkg::*;

  cfg_t cfg;
  in_t  in_data_r;
  logic in_valid_r;
  out_t upd;
  out_t out_data_r;
  logic out_valid_r;
  logic out_free;
  logic in_xfer;

  brpu_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  brpu_update u_update (
    .cfg  (cfg),
    .din  (in_data_r),
    .dout (upd)
  );

  // result register can take a new value when empty or being drained
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !out_free;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_free) out_valid_r <= in_valid_r;
      if (!in_stall) in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) in_data_r <= in_data;
    if (out_free && in_valid_r) out_data_r <= upd;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `BRPU_ASSERT_NOW(a_stall_when_full, in_valid_r && out_valid_r && out_stall, in_stall,
    "input must stall when both stages are full")
  `BRPU_ASSERT_NEXT(a_capture, in_xfer, in_valid_r,
    "accepted pixel not captured")
  `BRPU_ASSERT_NEXT(a_no_repeat, out_valid_r && !out_stall && !in_valid_r, !out_valid_r,
    "result repeated after transfer")
  `BRPU_ASSERT_NEXT(a_adjust_clears,
    in_valid_r && out_free &&
    (cfg.update_mode == MODE_ADJUST || cfg.update_mode == MODE_ADJUST_GATED),
    out_data_r.lo_count_out == K_ZERO && out_data_r.hi_count_out == K_ZERO,
    "adjust did not clear counters")

endmodule

// File: bench/brpu_result_checker.sv
`timescale 1ns / 100ps

module brpu_result_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [brpu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [brpu_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  brpu_pkg::in_t                  in_data,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  brpu_pkg::out_t                 out_data,
  output int                             fail_count,
  output int                             expected_left
);
  import brpu_pkg::*;

  // shadow copy of the mode and value registers
  mode_t            mode_q;
  logic [PIX_W-1:0] thr_q;
  logic [PIX_W-1:0] match_q;
  logic [PIX_W-1:0] fill_q;

  out_t pending_updates[$];
  out_t want_item;
  int   result_no;

  initial begin
    fail_count    = 0;
    expected_left = 0;
    result_no     = 0;
  end

  function automatic logic [PIX_W-1:0] clamp_add(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
    int s;
    s = int'(a) + int'(b);
    return (s > 255) ? K_ALL_ONES : s[PIX_W-1:0];
  endfunction

  function automatic logic [PIX_W-1:0] clamp_sub(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
    return (a < b) ? K_ZERO : a - b;
  endfunction

  function automatic out_t predict_pixel_update(input in_t d);
    out_t             r;
    logic [PIX_W-1:0] step_up;
    logic [PIX_W-1:0] step_dn;
    logic [PIX_W-1:0] mask;
    logic [PIX_W-1:0] grow;
    logic [PIX_W-1:0] shrink;
    logic             g;
    r.lo_out       = d.lo_in;
    r.hi_out       = d.hi_in;
    r.lo_count_out = d.lo_count_in;
    r.hi_count_out = d.hi_count_in;
    r.label_out    = d.label_in;
    case (mode_q)
      MODE_GROW_SLOW: begin
        if (d.pixel > d.hi_in) r.hi_out = clamp_add(d.hi_in, K8_ONE);
        if (d.pixel < d.lo_in) r.lo_out = clamp_sub(d.lo_in, K8_ONE);
      end
      MODE_GROW_FAST: begin
        if (d.pixel < d.lo_in) r.lo_out = d.pixel;
        if (d.pixel > d.hi_in) r.hi_out = d.pixel;
      end
      MODE_COUNT: begin
        if (d.pixel < d.lo_in) r.lo_count_out = clamp_add(d.lo_count_in, K8_ONE);
        if (d.pixel > d.hi_in) r.hi_count_out = clamp_add(d.hi_count_in, K8_ONE);
      end
      MODE_ADJUST, MODE_ADJUST_GATED: begin
        g = (mode_q == MODE_ADJUST) ? 1'b1 : d.gate[0];
        // add first, then subtract, each clamped
        step_up  = (g && d.lo_count_in < thr_q) ? K8_ONE : K_ZERO;
        step_dn  = (g && d.lo_count_in > thr_q) ? K8_ONE : K_ZERO;
        r.lo_out = clamp_sub(clamp_add(d.lo_in, step_up), step_dn);
        step_up  = (g && d.hi_count_in > thr_q) ? K8_ONE : K_ZERO;
        step_dn  = (g && d.hi_count_in < thr_q) ? K8_ONE : K_ZERO;
        r.hi_out = clamp_sub(clamp_add(d.hi_in, step_up), step_dn);
        r.lo_count_out = K_ZERO;
        r.hi_count_out = K_ZERO;
      end
      MODE_SHIFT, MODE_SHIFT_GATED: begin
        mask     = (mode_q == MODE_SHIFT) ? K_ALL_ONES : d.gate;
        grow     = mask & clamp_sub(d.pixel, d.hi_in);
        shrink   = mask & clamp_sub(d.lo_in, d.pixel);
        r.lo_out = clamp_sub(clamp_add(d.lo_in, grow), shrink);
        r.hi_out = clamp_sub(clamp_add(d.hi_in, grow), shrink);
      end
      default: begin
        if (d.pixel == match_q) r.label_out = fill_q;
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [PIX_W-1:0] got,
                             input logic [PIX_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %02h expected %02h",
                                result_no, name, got, want));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      mode_q  = MODE_GROW_SLOW;
      thr_q   = K_ZERO;
      match_q = K_ZERO;
      fill_q  = K_ZERO;
      pending_updates.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_UPDATE_MODE:     mode_q  = mode_t'(cfg_wdata[2:0]);
          REG_COUNT_THRESHOLD: thr_q   = cfg_wdata[PIX_W-1:0];
          REG_LABEL_MATCH:     match_q = cfg_wdata[PIX_W-1:0];
          REG_LABEL_FILL:      fill_q  = cfg_wdata[PIX_W-1:0];
        endcase
      end
      if (in_valid && !in_stall) pending_updates.push_back(predict_pixel_update(in_data));
      if (out_valid && !out_stall) begin
        if (pending_updates.size() == 0) begin
          report_mismatch($sformatf("result %0d transfer with nothing expected", result_no));
        end else begin
          want_item = pending_updates.pop_front();
          check_field("lo_out", out_data.lo_out, want_item.lo_out);
          check_field("hi_out", out_data.hi_out, want_item.hi_out);
          check_field("lo_count_out", out_data.lo_count_out, want_item.lo_count_out);
          check_field("hi_count_out", out_data.hi_count_out, want_item.hi_count_out);
          check_field("label_out", out_data.label_out, want_item.label_out);
        end
        result_no++;
      end
    end
    expected_left <= pending_updates.size();
  end

endmodule

// File: bench/tb_background_range_pixel_update.sv
`timescale 1ns / 100ps

module tb_background_range_pixel_update;
  import brpu_pkg::*;

  localparam int NUM_PHASES      = 24;
  localparam int ITEMS_PER_PHASE = 52;
  localparam int SQUEEZE_PHASE   = 5;
  localparam int SQUEEZE_CYCLES  = 200;
  localparam int DRAIN_CYCLES    = 10;
  localparam int RUN_LIMIT_NS    = 5_000_000;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_t                 out_data;

  int fail_count;
  int expected_left;
  bit sender_quiet;
  bit receiver_quiet;
  bit squeeze_req;

  background_range_pixel_update DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  brpu_result_checker u_result_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .expected_left (expected_left)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // writes all four registers back to back; upper mode bits are don't-care
  task automatic program_regs(input mode_t mode, input logic [PIX_W-1:0] thr,
                              input logic [PIX_W-1:0] match,
                              input logic [PIX_W-1:0] fill);
    logic [CFG_W-1:0] mode_word;
    mode_word = {5'($urandom), mode};
    cfg_we    <= 1'b1;
    cfg_index <= REG_UPDATE_MODE;
    cfg_wdata <= mode_word;
    @(posedge clk);
    cfg_index <= REG_COUNT_THRESHOLD;
    cfg_wdata <= thr;
    @(posedge clk);
    cfg_index <= REG_LABEL_MATCH;
    cfg_wdata <= match;
    @(posedge clk);
    cfg_index <= REG_LABEL_FILL;
    cfg_wdata <= fill;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic offer_pixel(input in_t item);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_pipeline_empty();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
  endtask

  // mostly bounds in order and pixels near the edges, some plain noise
  function automatic in_t random_pixel(input mode_t mode, input logic [PIX_W-1:0] thr,
                                       input logic [PIX_W-1:0] match);
    in_t              r;
    logic [PIX_W-1:0] swap;
    r.pixel       = 8'($urandom);
    r.lo_in       = 8'($urandom);
    r.hi_in       = 8'($urandom);
    r.lo_count_in = 8'($urandom);
    r.hi_count_in = 8'($urandom);
    r.gate        = 8'($urandom);
    r.label_in    = 8'($urandom);
    if ($urandom_range(0, 3) != 0 && r.lo_in > r.hi_in) begin
      swap    = r.lo_in;
      r.lo_in = r.hi_in;
      r.hi_in = swap;
    end
    case ($urandom_range(0, 5))
      0: r.pixel = r.lo_in;
      1: r.pixel = r.hi_in;
      2: r.pixel = r.lo_in - K8_ONE;
      3: r.pixel = r.hi_in + K8_ONE;
      default: ;
    endcase
    if (mode == MODE_LABEL && $urandom_range(0, 1) == 1) r.pixel = match;
    if ($urandom_range(0, 1) == 1) begin
      r.lo_count_in = thr + 8'($urandom_range(0, 2)) - K8_ONE;
      r.hi_count_in = thr + 8'($urandom_range(0, 2)) - K8_ONE;
    end
    if ($urandom_range(0, 7) == 0) r.lo_count_in = K_ALL_ONES;
    if ($urandom_range(0, 7) == 0) r.hi_count_in = K_ALL_ONES;
    return r;
  endfunction

  // receiver: random stall per result, quiet stretches, one long hold-off
  initial begin
    int hold;
    int done_count;
    done_count = 0;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        hold = SQUEEZE_CYCLES;
      end else if (receiver_quiet) begin
        hold = 0;
      end else begin
        hold = $urandom_range(0, 19);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      done_count++;
      if (done_count % 40 == 0) receiver_quiet = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    mode_t            mode;
    logic [PIX_W-1:0] thr;
    logic [PIX_W-1:0] match;
    logic [PIX_W-1:0] fill;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_UPDATE_MODE;
    cfg_wdata      <= K_ZERO;
    in_valid       <= 1'b0;
    in_data        <= '0;
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;
    squeeze_req    = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: saturation at both ends, pixel on the bounds, gate off and on
    program_regs(MODE_GROW_SLOW, K_ZERO, K_ZERO, K_ZERO);
    offer_pixel({8'hFF, 8'h00, 8'hFE, 8'h00, 8'h00, 8'h00, 8'h00});
    offer_pixel({8'h00, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    offer_pixel({8'h80, 8'h80, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00});
    wait_pipeline_empty();
    program_regs(MODE_GROW_FAST, K_ZERO, K_ZERO, K_ZERO);
    offer_pixel({8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    offer_pixel({8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    wait_pipeline_empty();
    program_regs(MODE_COUNT, K_ZERO, K_ZERO, K_ZERO);
    offer_pixel({8'h00, 8'h01, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00});
    offer_pixel({8'hFF, 8'h00, 8'hFE, 8'h00, 8'hFF, 8'h00, 8'h00});
    offer_pixel({8'h10, 8'h10, 8'h10, 8'h07, 8'h09, 8'h00, 8'h00});
    wait_pipeline_empty();
    program_regs(MODE_ADJUST, 8'h40, K_ZERO, K_ZERO);
    offer_pixel({8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00});
    offer_pixel({8'h00, 8'h00, 8'h00, 8'h41, 8'h3F, 8'h00, 8'h00});
    offer_pixel({8'h00, 8'h20, 8'h30, 8'h40, 8'h40, 8'h00, 8'h00});
    wait_pipeline_empty();
    program_regs(MODE_ADJUST_GATED, K_ALL_ONES, K_ZERO, K_ZERO);
    offer_pixel({8'h00, 8'h20, 8'h30, 8'h05, 8'h06, 8'hFE, 8'h00});
    offer_pixel({8'h00, 8'h20, 8'h30, 8'h00, 8'h00, 8'h01, 8'h00});
    wait_pipeline_empty();
    program_regs(MODE_SHIFT, K_ZERO, K_ZERO, K_ZERO);
    offer_pixel({8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    offer_pixel({8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00});
    offer_pixel({8'h50, 8'h40, 8'h60, 8'h00, 8'h00, 8'h00, 8'h00});
    wait_pipeline_empty();
    program_regs(MODE_SHIFT_GATED, K_ZERO, K_ZERO, K_ZERO);
    offer_pixel({8'hFF, 8'h00, 8'h10, 8'h00, 8'h00, 8'h0F, 8'h00});
    offer_pixel({8'h00, 8'hF0, 8'hFF, 8'h00, 8'h00, 8'hF0, 8'h00});
    wait_pipeline_empty();
    program_regs(MODE_LABEL, K_ZERO, K_ALL_ONES, K_ZERO);
    offer_pixel({8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hAA});
    offer_pixel({8'hFE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h55});
    wait_pipeline_empty();

    // random phases: each mode with low, high and random register values
    for (int p = 0; p < NUM_PHASES; p++) begin
      mode = mode_t'(p % 8);
      case (p / 8)
        0: begin
          thr   = K_ZERO;
          match = K_ZERO;
          fill  = K_ALL_ONES;
        end
        1: begin
          thr   = K_ALL_ONES;
          match = K_ALL_ONES;
          fill  = K_ZERO;
        end
        default: begin
          thr   = 8'($urandom);
          match = 8'($urandom);
          fill  = 8'($urandom);
        end
      endcase
      program_regs(mode, thr, match, fill);
      sender_quiet = (p == SQUEEZE_PHASE) || ($urandom_range(0, 3) == 0);
      if (p == SQUEEZE_PHASE) squeeze_req = 1'b1;
      repeat (ITEMS_PER_PHASE) offer_pixel(random_pixel(mode, thr, match));
      wait_pipeline_empty();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_left == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/brpu_pkg.sv
src/brpu_cfg.sv
src/brpu_update.sv
src/background_range_pixel_update.sv
bench/brpu_result_checker.sv
bench/tb_background_range_pixel_update.sv
